>>> sv/ssaf_pkg.sv
// Shared constants and types for the sensor sample to ASCII frame formatter.
// No dependencies; used by every module of the block.
`default_nettype none

package ssaf_pkg;

  // Field and register widths.
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned OFFSET_W = 28;
  localparam int unsigned PROD_W   = GAIN_W + SAMPLE_W;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DIGIT_W  = 4;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 8'd1;

  // Reset values of the calibration registers.
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd36225;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 28'd146360000;

  // Default number of decimal digits in a frame.
  localparam int unsigned NUM_DIGITS_DEF = 4;

  // Division by 1000 of a value below 2^28: multiply by ceil(2^38/1000), shift by 38.
  localparam int unsigned               RECIP1000_W     = 29;
  localparam logic [RECIP1000_W-1:0]    RECIP1000       = 29'd274877907;
  localparam int unsigned               RECIP1000_SHIFT = 38;
  localparam int unsigned               QUO_W           = 19;

  // Division by 10 of a value below 2^20: multiply by ceil(2^23/10), shift by 23.
  localparam int unsigned            RECIP10_W     = 20;
  localparam logic [RECIP10_W-1:0]   RECIP10       = 20'd838861;
  localparam int unsigned            RECIP10_SHIFT = 23;

  // Frame characters.
  localparam logic [BYTE_W-1:0] CH_STX  = 8'h02;
  localparam logic [BYTE_W-1:0] CH_DOT  = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ETX  = 8'h03;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

  // Queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Calibration settings handed to the front part.
  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [OFFSET_W-1:0] offset;
  } cal_cfg_t;

endpackage

`default_nettype wire

>>> sv/ssaf_front.sv
// Front part: calibrates a sample, scales it to 0.001 cm, saturates it and
// splits it into decimal digits in a stall-able pipeline. Uses ssaf_pkg.
`default_nettype none

module ssaf_front #(
  parameter int unsigned NUM_DIGITS = ssaf_pkg::NUM_DIGITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire ssaf_pkg::cal_cfg_t             cfg,
  input  wire logic                           in_fire,
  input  wire logic [ssaf_pkg::SAMPLE_W-1:0]  sample,
  output logic                                digits_valid,
  output logic [ssaf_pkg::DIGIT_W*NUM_DIGITS-1:0] digits
);

  localparam int unsigned FULL   = 10**NUM_DIGITS - 1;
  localparam int unsigned POS_W  = $clog2(FULL + 1);
  localparam int unsigned DIG_W  = ssaf_pkg::DIGIT_W * NUM_DIGITS;
  localparam int unsigned M10_W  = POS_W + ssaf_pkg::RECIP10_W;
  localparam int unsigned M1K_W  = ssaf_pkg::OFFSET_W + ssaf_pkg::RECIP1000_W;

  // Calibration stages.
  logic                            v1, v2, v3;
  logic [ssaf_pkg::PROD_W-1:0]     prod1;
  logic [ssaf_pkg::OFFSET_W-1:0]   diff2;
  logic [ssaf_pkg::QUO_W-1:0]      quo3;

  // Digit stages: index 0 holds the saturated position, stage i+1 has digit i.
  logic                  dvalid [NUM_DIGITS+1];
  logic [POS_W-1:0]      dval   [NUM_DIGITS+1];
  logic [DIG_W-1:0]      ddig   [NUM_DIGITS+1];

  logic [M1K_W-1:0]               mul1k;
  logic [M1K_W-1:0]               mul1k_sh;
  logic [ssaf_pkg::PROD_W-1:0]    diff_c;
  logic [POS_W-1:0]               pos_c;

  logic [M10_W-1:0]   mul10   [NUM_DIGITS];
  logic [M10_W-1:0]   mul10_sh[NUM_DIGITS];
  logic [POS_W-1:0]   quo10   [NUM_DIGITS];
  logic [POS_W-1:0]   rem_full[NUM_DIGITS];
  logic [ssaf_pkg::DIGIT_W-1:0] rem10[NUM_DIGITS];
  logic [DIG_W-1:0]   ddig_next[NUM_DIGITS];

  // Offset removal clamps at zero instead of wrapping.
  always_comb begin
    if (prod1 > ssaf_pkg::PROD_W'(cfg.offset)) begin
      diff_c = prod1 - ssaf_pkg::PROD_W'(cfg.offset);
    end else begin
      diff_c = '0;
    end
  end

  // Divide by 1000 through a reciprocal multiply.
  always_comb begin
    mul1k    = M1K_W'(diff2) * M1K_W'(ssaf_pkg::RECIP1000);
    mul1k_sh = mul1k >> ssaf_pkg::RECIP1000_SHIFT;
  end

  // Saturate to the largest value the digits can show.
  always_comb begin
    if (32'(quo3) > 32'(FULL)) begin
      pos_c = POS_W'(FULL);
    end else begin
      pos_c = POS_W'(quo3);
    end
  end

  // One divide by ten per digit stage; the new digit joins those already found.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      mul10[i]    = M10_W'(dval[i]) * M10_W'(ssaf_pkg::RECIP10);
      mul10_sh[i] = mul10[i] >> ssaf_pkg::RECIP10_SHIFT;
      quo10[i]    = mul10_sh[i][POS_W-1:0];
      rem_full[i] = dval[i] - POS_W'(quo10[i] * POS_W'(10));
      rem10[i]    = rem_full[i][ssaf_pkg::DIGIT_W-1:0];
      ddig_next[i] = ddig[i];
      ddig_next[i][ssaf_pkg::DIGIT_W*i +: ssaf_pkg::DIGIT_W] = rem10[i];
    end
  end

  // Pipeline registers; the whole pipe holds while en is low.
  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= ssaf_pkg::PROD_W'(cfg.gain) * ssaf_pkg::PROD_W'(sample);
      diff2 <= ssaf_pkg::OFFSET_W'(diff_c);
      quo3  <= mul1k_sh[ssaf_pkg::QUO_W-1:0];
      dval[0] <= pos_c;
      ddig[0] <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        dval[i+1] <= quo10[i];
        ddig[i+1] <= ddig_next[i];
      end
    end
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int i = 0; i <= NUM_DIGITS; i++) begin
        dvalid[i] <= 1'b0;
      end
    end else if (en) begin
      v1 <= in_fire;
      v2 <= v1;
      v3 <= v2;
      dvalid[0] <= v3;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        dvalid[i+1] <= dvalid[i];
      end
    end
  end

  assign digits_valid = dvalid[NUM_DIGITS] & en;
  assign digits       = ddig[NUM_DIGITS];

endmodule

`default_nettype wire

>>> sv/ssaf_fifo.sv
// Short register queue of digit sets between the front and back parts.
// Uses ssaf_pkg for its depth.
`default_nettype none

module ssaf_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = ssaf_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

endmodule

`default_nettype wire

>>> sv/ssaf_back.sv
// Back part: walks one digit set through the ASCII frame, one byte per beat,
// into a registered output stage. Uses ssaf_pkg for the frame characters.
`default_nettype none

module ssaf_back #(
  parameter int unsigned NUM_DIGITS = ssaf_pkg::NUM_DIGITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   have_item,
  input  wire logic [ssaf_pkg::DIGIT_W*NUM_DIGITS-1:0] digits,
  output logic                                        pop,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [ssaf_pkg::BYTE_W-1:0]                 frame_byte,
  output logic                                        last
);

  localparam int unsigned FRAME_LEN = NUM_DIGITS + 4;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

  logic [IDX_W-1:0]              idx;
  logic                          advance;
  logic                          at_end;
  logic [ssaf_pkg::BYTE_W-1:0]   byte_c;

  assign advance = have_item && (!out_valid || !out_stall);
  assign at_end  = (idx == IDX_W'(FRAME_LEN - 1));
  assign pop     = advance && at_end;

  // Pick the frame byte for the current position.
  always_comb begin
    byte_c = ssaf_pkg::CH_ETX;
    for (int k = 0; k < NUM_DIGITS - 1; k++) begin
      if (idx == IDX_W'(NUM_DIGITS + 1 - k)) begin
        byte_c = ssaf_pkg::CH_ZERO +
                 ssaf_pkg::BYTE_W'(digits[ssaf_pkg::DIGIT_W*k +: ssaf_pkg::DIGIT_W]);
      end
    end
    if (idx == IDX_W'(0)) begin
      byte_c = ssaf_pkg::CH_STX;
    end else if (idx == IDX_W'(1)) begin
      byte_c = ssaf_pkg::CH_ZERO + ssaf_pkg::BYTE_W'(
               digits[ssaf_pkg::DIGIT_W*(NUM_DIGITS-1) +: ssaf_pkg::DIGIT_W]);
    end else if (idx == IDX_W'(2)) begin
      byte_c = ssaf_pkg::CH_DOT;
    end else if (idx == IDX_W'(NUM_DIGITS + 2)) begin
      byte_c = ssaf_pkg::CH_CR;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      frame_byte <= byte_c;
      last       <= at_end;
    end
  end

  // Byte position and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
      idx       <= at_end ? '0 : idx + 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> sv/sensor_sample_to_ascii_frame_top.sv
// Top level of the sensor sample to ASCII frame formatter: calibration
// registers, front pipeline, digit queue and frame sender. Uses ssaf_pkg.
`default_nettype none

// Each accepted 12-bit sample becomes a frame of NUM_DIGITS + 4 bytes
// (eight by default: STX, first digit, '.', remaining digits, CR, ETX) giving
// (gain * sample - offset) / 1000 in 0.001 cm, clamped to 0 and to the largest
// value the digits can show. The frame sender emits one byte per cycle while it
// has a sample queued and the output is not stalled, and it sets the sustained
// rate. A sample passes the calibration and digit stages before it reaches the
// queue, and the queue holds four finished samples, so input is taken while
// earlier frames are still going out. Configuration writes are always ready
// and should be made only while no frame is pending.
module sensor_sample_to_ascii_frame_top #(
  parameter int unsigned NUM_DIGITS = ssaf_pkg::NUM_DIGITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [ssaf_pkg::SAMPLE_W-1:0]      sample,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [ssaf_pkg::BYTE_W-1:0]             frame_byte,
  output logic                                    last,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ssaf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ssaf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned DIG_W = ssaf_pkg::DIGIT_W * NUM_DIGITS;

  ssaf_pkg::cal_cfg_t cfg;
  logic               en;
  logic               in_fire;
  logic               q_full;
  logic               q_not_empty;
  logic               q_pop;
  logic               dig_valid;
  logic [DIG_W-1:0]   dig;
  logic [DIG_W-1:0]   q_head;

  assign cfg_ready = 1'b1;

  // Calibration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain   <= ssaf_pkg::GAIN_RESET;
      cfg.offset <= ssaf_pkg::OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssaf_pkg::REG_GAIN:   cfg.gain   <= cfg_data[ssaf_pkg::GAIN_W-1:0];
        ssaf_pkg::REG_OFFSET: cfg.offset <= cfg_data[ssaf_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // The front pipe moves only while the queue has room.
  assign en       = !q_full;
  assign in_stall = q_full;
  assign in_fire  = in_valid && !in_stall;

  ssaf_front #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cfg          (cfg),
    .in_fire      (in_fire),
    .sample       (sample),
    .digits_valid (dig_valid),
    .digits       (dig)
  );

  ssaf_fifo #(
    .WIDTH (DIG_W),
    .DEPTH (ssaf_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (dig_valid),
    .push_data (dig),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  ssaf_back #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .have_item  (q_not_empty),
    .digits     (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .last       (last)
  );

endmodule

`default_nettype wire
